/* rtl/typed_bytes_to_double_decoder_assert.svh */
// Assertion macros for the typed bytes to double decoder
`ifndef TYPED_BYTES_TO_DOUBLE_DECODER_ASSERT_SVH
`define TYPED_BYTES_TO_DOUBLE_DECODER_ASSERT_SVH

`define TBDD_ASSERT_IMPL(label, clk, rstn, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (conseq)) \
        else $error(msg);

`define TBDD_ASSERT_NEXT(label, clk, cond, conseq, msg) \
    label: assert property (@(posedge clk) (cond) |=> (conseq)) else $error(msg);

`endif

/* rtl/tbdd_pkg.sv */
// Package for the typed bytes to double decoder: payload types and key characters
package tbdd_pkg;

    localparam int MaxBytesDefault = 8;

    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChU     = 8'h75;
    localparam logic [7:0] ChS     = 8'h73;
    localparam logic [7:0] ChI     = 8'h69;
    localparam logic [7:0] ChF     = 8'h66;
    localparam logic [7:0] ChL     = 8'h6C;
    localparam logic [7:0] ChA     = 8'h61;
    localparam logic [7:0] ChG     = 8'h67;
    localparam logic [7:0] ChT     = 8'h74;
    localparam logic [7:0] ChP     = 8'h70;
    localparam logic [7:0] Ch0     = 8'h30;
    localparam logic [7:0] Ch1     = 8'h31;
    localparam logic [7:0] Ch2     = 8'h32;
    localparam logic [7:0] Ch3     = 8'h33;
    localparam logic [7:0] Ch4     = 8'h34;
    localparam logic [7:0] Ch6     = 8'h36;
    localparam logic [7:0] Ch8     = 8'h38;
    localparam logic [7:0] Ch9     = 8'h39;

    localparam logic [63:0] DblOne = 64'h3FF0_0000_0000_0000;

    typedef struct packed {
        logic [31:0] type_key;
        logic [63:0] data_bytes;
        logic [5:0]  byte_count;
    } in_t;

    typedef struct packed {
        logic [63:0] value_bits;
        logic        valid_res;
    } out_t;

endpackage

/* rtl/typed_bytes_to_double_decoder.sv */
// Top level: decodes a typed key and data bytes into IEEE-754 double bits
// Path: the input register holds the request, then the result register holds its decoded value.
// Throughput: one request per cycle while the sink is ready; the conversion logic sits between the two registers.
// A request waits in the input register while a result waits in the result register.
// Reset: synchronous active-low aresetn clears both stage valid flags; payload is not reset.
module typed_bytes_to_double_decoder #(
    parameter int MAX_BYTES = tbdd_pkg::MaxBytesDefault
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  tbdd_pkg::in_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output tbdd_pkg::out_t m_data
);

    localparam logic [5:0] MaxB = 6'(MAX_BYTES);

    tbdd_pkg::in_t  in_reg;
    logic           in_vld_reg;
    tbdd_pkg::out_t out_reg, out_next;
    logic           out_vld_reg;
    logic           adv;

    assign adv     = !out_vld_reg || m_ready;
    assign s_ready = !in_vld_reg || adv;
    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (adv) begin
                out_vld_reg <= in_vld_reg;
            end
        end
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
        if (adv && in_vld_reg) begin
            out_reg <= out_next;
        end
    end

    logic [7:0]  k0, k1, k2, k3;
    logic [5:0]  cnt;
    logic [3:0]  n;
    logic [6:0]  rsh;
    logic [63:0] be, u, mask, mag, norm, dbl;
    logic [63:0] data;
    logic        neg;
    logic [3:0]  down;
    logic [5:0]  p;
    logic [10:0] ex;
    logic        rnd;
    logic        is_ui, is_si, is_flag, is_flt, is_fp;
    logic        hex_ok;
    logic [3:0]  hexv;
    logic [31:0] f;
    logic [22:0] fm;
    logic [4:0]  fp;
    logic [63:0] fdbl, fsh;
    logic [15:0] u16;

    always_comb begin
        k0 = in_reg.type_key[7:0];
        k1 = in_reg.type_key[15:8];
        k2 = in_reg.type_key[23:16];
        k3 = in_reg.type_key[31:24];
        data = in_reg.data_bytes;
        cnt  = in_reg.byte_count;
        n    = (cnt > MaxB) ? MaxB[3:0] : cnt[3:0];
        rsh  = 7'd64 - {n, 3'b000};

        is_ui = (k0 == tbdd_pkg::ChU) && (k1 == tbdd_pkg::ChI) &&
                (((k2 == tbdd_pkg::Ch8) && (k3 == tbdd_pkg::ChSpace)) ||
                 ((k2 == tbdd_pkg::Ch1) && (k3 == tbdd_pkg::Ch6)) ||
                 ((k2 == tbdd_pkg::Ch3) && (k3 == tbdd_pkg::Ch2)) ||
                 ((k2 == tbdd_pkg::Ch6) && (k3 == tbdd_pkg::Ch4)));
        is_si = (k0 == tbdd_pkg::ChS) && (k1 == tbdd_pkg::ChI) &&
                (((k2 == tbdd_pkg::Ch8) && (k3 == tbdd_pkg::ChSpace)) ||
                 ((k2 == tbdd_pkg::Ch1) && (k3 == tbdd_pkg::Ch6)) ||
                 ((k2 == tbdd_pkg::Ch3) && (k3 == tbdd_pkg::Ch2)) ||
                 ((k2 == tbdd_pkg::Ch6) && (k3 == tbdd_pkg::Ch4)));
        is_flag = (k0 == tbdd_pkg::ChF) && (k1 == tbdd_pkg::ChL) &&
                  (k2 == tbdd_pkg::ChA) && (k3 == tbdd_pkg::ChG);
        is_flt = (k0 == tbdd_pkg::ChF) && (k1 == tbdd_pkg::ChL) &&
                 (k2 == tbdd_pkg::ChT) && (k3 == tbdd_pkg::ChSpace);
        is_fp = ((k0 == tbdd_pkg::ChS) || (k0 == tbdd_pkg::ChF)) && (k1 == tbdd_pkg::ChP);

        hex_ok = 1'b1;
        hexv   = 4'd0;
        if (k3 >= tbdd_pkg::Ch0 && k3 <= tbdd_pkg::Ch9) begin
            hexv = 4'(k3 - tbdd_pkg::Ch0);
        end else if (k3 >= 8'h61 && k3 <= 8'h66) begin
            hexv = 4'(k3 - 8'h57);
        end else if (k3 >= 8'h41 && k3 <= 8'h46) begin
            hexv = 4'(k3 - 8'h37);
        end else begin
            hex_ok = 1'b0;
        end

        for (int i = 0; i < 8; i++) begin
            be[63 - 8 * i -: 8] = data[8 * i +: 8];
        end
        u16 = {data[7:0], data[15:8]};

        u    = be >> rsh;
        mask = ~64'd0 >> rsh;
        neg  = 1'b0;
        down = 4'd0;
        if (is_fp) begin
            down = hexv;
            neg  = (k0 == tbdd_pkg::ChS) && u16[15];
            mag  = neg ? {48'd0, 16'(~u16 + 16'd1)} : {48'd0, u16};
        end else begin
            neg  = is_si && be[63];
            mag  = neg ? ((~u + 64'd1) & mask) : u;
        end

        p = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (mag[i]) begin
                p = 6'(i);
            end
        end
        norm = mag << (6'd63 - p);
        rnd  = norm[10] && ((|norm[9:0]) || norm[11]);
        ex   = 11'(11'd1022 + {5'd0, p} - {7'd0, down});
        dbl  = {1'b0, ex, 52'd0} + {11'd0, 1'b1, norm[62:11]} + {63'd0, rnd};
        if (mag == 64'd0) begin
            dbl = 64'd0;
        end else begin
            dbl[63] = neg;
        end

        f  = data[31:0];
        fm = f[22:0];
        fp = 5'd0;
        for (int i = 0; i < 23; i++) begin
            if (fm[i]) begin
                fp = 5'(i);
            end
        end
        fsh = {41'd0, fm} << (6'd52 - {1'b0, fp});
        if (f[30:23] == 8'hFF) begin
            fdbl = {f[31], 11'h7FF, (fm != 23'd0), fm[21:0], 29'd0};
            if (fm != 23'd0) begin
                fdbl[51] = 1'b1;
                fdbl[50:29] = fm[21:0];
            end
        end else if (f[30:23] == 8'h00) begin
            if (fm == 23'd0) begin
                fdbl = {f[31], 63'd0};
            end else begin
                fdbl = {f[31], 11'(11'd874 + {6'd0, fp}), fsh[51:0]};
            end
        end else begin
            fdbl = {f[31], 11'({3'd0, f[30:23]} + 11'd896), fm, 29'd0};
        end

        out_next = '0;
        if (cnt != 6'd0) begin
            if (is_ui || is_si) begin
                out_next.value_bits = dbl;
                out_next.valid_res  = 1'b1;
            end else if (is_flag) begin
                out_next.value_bits = (data[7:0] != 8'd0) ? tbdd_pkg::DblOne : 64'd0;
                out_next.valid_res  = 1'b1;
            end else if (is_flt) begin
                if (cnt >= 6'd4) begin
                    out_next.value_bits = fdbl;
                    out_next.valid_res  = 1'b1;
                end
            end else if (is_fp && cnt >= 6'd2 && hex_ok) begin
                out_next.value_bits = dbl;
                out_next.valid_res  = 1'b1;
            end
        end
    end

`include "typed_bytes_to_double_decoder_assert.svh"

    `TBDD_ASSERT_IMPL(a_invalid_zero, aclk, aresetn, m_valid && !m_data.valid_res, m_data.value_bits == 64'd0, "invalid result carries nonzero bits")
    `TBDD_ASSERT_IMPL(a_stage_moves, aclk, aresetn, in_vld_reg && adv, ##1 m_valid, "staged request did not reach result register")
    `TBDD_ASSERT_IMPL(a_ready_free, aclk, aresetn, !m_valid, s_ready, "input blocked with empty result register")
    `TBDD_ASSERT_NEXT(a_reset_clear, aclk, !aresetn, !m_valid && !in_vld_reg, "reset did not clear valid flags")

endmodule

/* verif/tb.sv */
// Testbench for the typed bytes to double decoder: random and directed requests, checked
`timescale 1ns / 100ps

class decode_scoreboard;
    tbdd_pkg::out_t pending_q[$];
    int unsigned    mismatches;
    int unsigned    matched;
    int unsigned    valid_seen;

    function automatic logic [63:0] int_bits(logic neg, logic [63:0] mag, int unsigned down);
        int          p;
        int          sh;
        logic [63:0] mant;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] ex;
        if (mag == 0) return 64'd0;
        p = 0;
        for (int i = 0; i < 64; i++) if (mag[i]) p = i;
        if (p <= 52) begin
            mant = mag << (52 - p);
        end else begin
            sh   = p - 52;
            rem  = mag & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            mant = mag >> sh;
            if (rem > half || (rem == half && mant[0])) mant = mant + 64'd1;
        end
        ex = 64'(1023 + p - int'(down));
        return ({63'd0, neg} << 63) + ((ex - 64'd1) << 52) + mant;
    endfunction

    function automatic logic [63:0] be_read(logic [63:0] d, int unsigned n);
        logic [63:0] v;
        v = 0;
        for (int i = 0; i < n && i < 8; i++) v = (v << 8) | {56'd0, d[8*i +: 8]};
        return v;
    endfunction

    function automatic logic [63:0] sint_bits(logic [63:0] u, int unsigned n, int unsigned down);
        logic [63:0] mask;
        mask = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
        if (u[8*n-1]) return int_bits(1'b1, (~u + 64'd1) & mask, down);
        return int_bits(1'b0, u, down);
    endfunction

    function automatic logic [63:0] widen(logic [31:0] f);
        logic [63:0] s;
        logic [63:0] m;
        int          p;
        s = {f[31], 63'd0};
        m = {41'd0, f[22:0]};
        if (f[30:23] == 8'hFF) begin
            if (m == 0) return s | (64'h7FF << 52);
            return s | (64'h7FF << 52) | (64'd1 << 51) | (m << 29);
        end
        if (f[30:23] == 0) begin
            if (m == 0) return s;
            p = 0;
            for (int i = 0; i < 23; i++) if (m[i]) p = i;
            return s | (64'(1023 + p - 149) << 52) | ((m << (52 - p)) & 64'h000F_FFFF_FFFF_FFFF);
        end
        return s | (64'({24'd0, f[30:23]} - 127 + 1023) << 52) | (m << 29);
    endfunction

    function automatic int hex_digit(logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic tbdd_pkg::out_t decode(tbdd_pkg::in_t req);
        logic [7:0]  k[4];
        logic [31:0] key;
        int unsigned len;
        int unsigned n;
        int          fr;
        tbdd_pkg::out_t r;
        r = '0;
        for (int i = 0; i < 4; i++) begin
            k[i] = req.type_key[8*i +: 8];
            if (k[i] < 8'd32 || k[i] > 8'd126) k[i] = ".";
        end
        len = 4;
        while (len > 0 && k[len-1] == tbdd_pkg::ChSpace) len--;
        key = {k[3], k[2], k[1], k[0]};
        n = req.byte_count < tbdd_pkg::MaxBytesDefault ? req.byte_count
                                                        : tbdd_pkg::MaxBytesDefault;
        if (req.byte_count == 0) return r;
        if ((len == 3 && key[23:0] == "8iu") || (len == 4 && (key == "61iu" ||
            key == "23iu" || key == "46iu"))) begin
            r = {int_bits(1'b0, be_read(req.data_bytes, n), 0), 1'b1};
        end else if ((len == 3 && key[23:0] == "8is") || (len == 4 && (key == "61is" ||
                     key == "23is" || key == "46is"))) begin
            r = {sint_bits(be_read(req.data_bytes, n), n, 0), 1'b1};
        end else if (len == 4 && key == "galf") begin
            r = {(req.data_bytes[7:0] != 0) ? tbdd_pkg::DblOne : 64'd0, 1'b1};
        end else if (len == 3 && key[23:0] == "tlf") begin
            if (req.byte_count >= 4) r = {widen(req.data_bytes[31:0]), 1'b1};
        end else if (len == 4 && (k[0] == "s" || k[0] == "f") && k[1] == "p"
                     && req.byte_count >= 2) begin
            fr = hex_digit(k[3]);
            if (fr >= 0) begin
                if (k[0] == "s") r = {sint_bits(be_read(req.data_bytes, 2), 2, fr), 1'b1};
                else r = {int_bits(1'b0, be_read(req.data_bytes, 2), fr), 1'b1};
            end
        end
        return r;
    endfunction

    function void note_request(tbdd_pkg::in_t req);
        pending_q.push_back(decode(req));
    endfunction

    function void check_result(tbdd_pkg::out_t got);
        tbdd_pkg::out_t want;
        if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
        end
        want = pending_q.pop_front();
        if (got.valid_res) valid_seen++;
        if (got.value_bits !== want.value_bits || got.valid_res !== want.valid_res) begin
            mismatches++;
            if (mismatches <= 10)
                $display("bad result: expected %h/%b got %h/%b", want.value_bits,
                         want.valid_res, got.value_bits, got.valid_res);
        end else begin
            matched++;
        end
    endfunction
endclass

module tb;
    logic           aclk;
    logic           aresetn;
    logic           s_valid;
    logic           s_ready;
    tbdd_pkg::in_t  s_data;
    logic           m_valid;
    logic           m_ready;
    tbdd_pkg::out_t m_data;
    decode_scoreboard results;
    int unsigned    cycle_count;
    int unsigned    hold_cycles;
    bit             calm;

    typed_bytes_to_double_decoder i_dut (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [31:0] pick_key();
        logic [7:0]  c;
        logic [31:0] key;
        c = 8'($urandom_range(0, 15));
        c = (c < 10) ? 8'("0") + c : 8'("a") + c - 8'd10;
        case ($urandom_range(0, 13))
            0: key = " 8iu";
            1: key = "61iu";
            2: key = "23iu";
            3: key = "46iu";
            4: key = " 8is";
            5: key = "61is";
            6: key = "23is";
            7: key = "46is";
            8: key = "galf";
            9: key = " tlf";
            10: key = {c, 24'h007073};
            11: key = {c, 24'h007066};
            12: key = $urandom;
            default: key = {$urandom_range(0, 1) ? "F" : "g", 8'h00,
                            $urandom_range(0, 1) ? "p" : 8'h01, "s"};
        endcase
        if (key[31:24] == 8'h00) key[31:24] = $urandom_range(0, 1) ? 8'h20 : 8'h00;
        if (key[23:16] == "p") key = {key[31:24], "p", key[15:0]};
        if (key[31:24] == 8'h00 && key[23:16] == 8'h00) key[31:24] = "z";
        return key;
    endfunction

    task automatic send_request(tbdd_pkg::in_t req);
        int unsigned gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  <= req;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        results.note_request(req);
        @(negedge aclk);
    endtask

    task automatic send_mix(logic [31:0] key, logic [63:0] d, logic [5:0] n);
        tbdd_pkg::in_t req;
        req.type_key   = key;
        req.data_bytes = d;
        req.byte_count = n;
        send_request(req);
    endtask

    // sink side
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) results.check_result(m_data);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > 200000) begin
            $display("typed_bytes_to_double_decoder: mismatch");
            $finish;
        end
    end

    initial begin
        tbdd_pkg::in_t req;
        int unsigned   settle;
        results  = new();
        aresetn  = 1'b0;
        s_valid  = 1'b0;
        s_data   = '0;
        calm     = 1'b0;
        hold_cycles = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_mix("46iu", 64'hFFFF_FFFF_FFFF_FFFF, 6'd8);
        send_mix("46iu", 64'h0, 6'd8);
        send_mix("46is", 64'h0000_0000_0000_0080, 6'd63);
        send_mix(" 8is", 64'h80, 6'd1);
        send_mix(" 8iu", 64'hFF, 6'd1);
        send_mix("61is", 64'hFFFF, 6'd2);
        send_mix("23iu", 64'h0100_0000_0000_0001, 6'd32);
        send_mix("galf", 64'h0, 6'd1);
        send_mix("galf", 64'hFFFF_FFFF_FFFF_FF01, 6'd1);
        send_mix("galf", 64'h1, 6'd0);
        send_mix(" tlf", 64'h7FC0_0001, 6'd4);
        send_mix(" tlf", 64'hFF80_0000, 6'd4);
        send_mix(" tlf", 64'h8000_0000, 6'd4);
        send_mix(" tlf", 64'h0000_0001, 6'd4);
        send_mix(" tlf", 64'h3F80_0000, 6'd3);
        send_mix("8fps", 64'hFF7F, 6'd2);
        send_mix("Ffps", 64'hFFFF, 6'd2);
        send_mix("00pf", 64'hFFFF, 6'd2);
        send_mix("gfps", 64'h1234, 6'd2);
        send_mix("88ps", 64'h0080, 6'd1);
        send_mix("dlro", 64'h1234, 6'd8);
        send_mix({8'h7F, 8'h1F, "iu"}, 64'h1, 6'd1);

        for (int i = 0; i < 1200; i++) begin
            if (i == 400) hold_cycles = 300;
            if (i == 1050) calm = 1'b1;
            req.type_key   = pick_key();
            req.data_bytes = {$urandom, $urandom};
            if ($urandom_range(0, 3) == 0) req.data_bytes = req.data_bytes >> $urandom_range(0, 63);
            req.byte_count = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                        : 6'($urandom_range(0, 8));
            send_request(req);
        end
        s_valid <= 1'b0;
        while (results.pending_q.size() != 0) @(posedge aclk);
        settle = 0;
        while (settle < 10) begin
            @(posedge aclk);
            settle++;
        end
        $display("decoded %0d requests, %0d with a valid value, all key families and counts",
                 results.matched + results.mismatches, results.valid_seen);
        if (results.mismatches == 0) begin
            $display("typed_bytes_to_double_decoder: match");
        end else begin
            $display("typed_bytes_to_double_decoder: mismatch");
        end
        $finish;
    end
endmodule
